[design/sfwd_pkg.sv]
`default_nettype none
package sfwd_pkg;

   localparam logic [7:0] SYNC_BYTE    = 8'hFF;
   localparam logic [7:0] LEN_OVERHEAD = 8'd3;
   localparam logic [7:0] WORD_BYTES   = 8'd2;
   localparam logic [7:0] IDENT_BYTE   = 8'h00;

   localparam int KIND_W  = 2;
   localparam int VALUE_W = 16;
   localparam int INDEX_W = 7;
   localparam int COUNT_W = 7;

   localparam logic [KIND_W-1:0] KIND_WORD     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ACCEPTED = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REJECTED = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0]  result_kind;
      logic [VALUE_W-1:0] word_value;
      logic [INDEX_W-1:0] word_index;
      logic [COUNT_W-1:0] word_count;
   } result_type;

endpackage
`default_nettype wire

[design/sfwd_parser.sv]
`default_nettype none
module sfwd_parser
   import sfwd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_rx_byte,
   input  wire logic       out_space,
   output logic            push,
   output result_type      push_result
);

   typedef enum logic [2:0] {
      PH_HUNT0 = 3'd0,
      PH_HUNT1 = 3'd1,
      PH_LEN   = 3'd2,
      PH_IDENT = 3'd3,
      PH_LOW   = 3'd4,
      PH_HIGH  = 3'd5
   } phase_type;

   logic               in_valid_ff;
   logic [7:0]         in_byte_ff;
   logic               advance;
   logic               load;

   phase_type          phase_ff, phase_in;
   logic [7:0]         remain_ff, remain_in;
   logic [7:0]         sum_ff, sum_in;
   logic [7:0]         low_ff, low_in;
   logic [COUNT_W-1:0] words_ff, words_in;
   logic               emit;
   result_type         res;
   logic [7:0]         sum_next;

   assign advance   = in_valid_ff && out_space;
   assign req_stall = in_valid_ff && !out_space;
   assign load      = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (load) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
      if (load) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   assign sum_next = sum_ff + in_byte_ff;

   always_comb begin
      phase_in  = phase_ff;
      remain_in = remain_ff;
      sum_in    = sum_ff;
      low_in    = low_ff;
      words_in  = words_ff;
      emit      = 1'b0;
      res       = '0;
      case (phase_ff)
         PH_HUNT1: begin
            phase_in = (in_byte_ff == SYNC_BYTE) ? PH_LEN : PH_HUNT0;
         end
         PH_LEN: begin
            // odd lengths of 3 or more only
            if (in_byte_ff < LEN_OVERHEAD || !in_byte_ff[0]) begin
               phase_in = PH_HUNT0;
            end else begin
               remain_in = in_byte_ff - LEN_OVERHEAD;
               sum_in    = '0;
               words_in  = '0;
               phase_in  = PH_IDENT;
            end
         end
         PH_IDENT: begin
            phase_in = (in_byte_ff == IDENT_BYTE) ? PH_LOW : PH_HUNT0;
         end
         PH_LOW: begin
            if (remain_ff == '0) begin
               // checksum byte
               emit             = 1'b1;
               res.result_kind  = (sum_next == '0) ? KIND_ACCEPTED : KIND_REJECTED;
               res.word_count   = words_ff;
               sum_in           = '0;
               words_in         = '0;
               phase_in         = PH_HUNT0;
            end else begin
               sum_in   = sum_next;
               low_in   = in_byte_ff;
               phase_in = PH_HIGH;
            end
         end
         PH_HIGH: begin
            emit             = 1'b1;
            res.result_kind  = KIND_WORD;
            res.word_value   = {in_byte_ff, low_ff};
            res.word_index   = words_ff;
            sum_in           = sum_next;
            remain_in        = (remain_ff >= WORD_BYTES) ? remain_ff - WORD_BYTES : '0;
            words_in         = words_ff + 1'b1;
            phase_in         = PH_LOW;
         end
         default: begin
            phase_in = (in_byte_ff == SYNC_BYTE) ? PH_HUNT1 : PH_HUNT0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT0;
         remain_ff <= '0;
         sum_ff    <= '0;
         low_ff    <= '0;
         words_ff  <= '0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         remain_ff <= remain_in;
         sum_ff    <= sum_in;
         low_ff    <= low_in;
         words_ff  <= words_in;
      end
   end

   assign push        = advance && emit;
   assign push_result = res;

   a_word_then_low: assert property (@(posedge clock) disable iff (reset)
      (push && push_result.result_kind == KIND_WORD) |=> (phase_ff == PH_LOW))
      else $error("word item not followed by low byte phase");

   a_frame_end_hunts: assert property (@(posedge clock) disable iff (reset)
      (push && push_result.result_kind != KIND_WORD) |=> (phase_ff == PH_HUNT0 && words_ff == '0))
      else $error("frame end did not restart the hunt");

endmodule
`default_nettype wire

[design/sfwd_out_fifo.sv]
`default_nettype none
module sfwd_out_fifo
   import sfwd_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire result_type         push_result,
   output logic                    space,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [KIND_W-1:0]       rsp_result_kind,
   output logic [VALUE_W-1:0]      rsp_word_value,
   output logic [INDEX_W-1:0]      rsp_word_index,
   output logic [COUNT_W-1:0]      rsp_word_count
);

   result_type  store_ff [2];
   logic        wr_ptr_ff;
   logic        rd_ptr_ff;
   logic [1:0]  count_ff;
   logic        pop;
   result_type  head;

   assign space     = (count_ff != 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign pop       = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
      if (push) begin
         store_ff[wr_ptr_ff] <= push_result;
      end
   end

   assign head            = store_ff[rd_ptr_ff];
   assign rsp_result_kind = head.result_kind;
   assign rsp_word_value  = head.word_value;
   assign rsp_word_index  = head.word_index;
   assign rsp_word_count  = head.word_count;

   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd2) |-> !push)
      else $error("push into a full output buffer");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("output buffer count out of range");

endmodule
`default_nettype wire

[design/sync_frame_word_deframer.sv]
`default_nettype none
// Channel | Ports                                     | Direction
// req     | req_valid, req_stall, req_rx_byte         | byte in
// rsp     | rsp_valid, rsp_stall, rsp_result_kind,    | word / frame status out
//         | rsp_word_value, rsp_word_index,           |
//         | rsp_word_count                            |
//
// One byte is taken per clock while req_stall is low; the parse step sits between
// the input register and a two-entry output buffer, so each byte is registered before parsing.
// Synchronous active-high reset puts the parser into sync hunt, empties both stages.
// req_stall rises only while the input register holds a byte and the output
// buffer is full; rsp_stall never reaches req_stall combinationally.
module sync_frame_word_deframer
   import sfwd_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [7:0]         req_rx_byte,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [KIND_W-1:0]       rsp_result_kind,
   output logic [VALUE_W-1:0]      rsp_word_value,
   output logic [INDEX_W-1:0]      rsp_word_index,
   output logic [COUNT_W-1:0]      rsp_word_count
);

   logic       out_space;
   logic       push;
   result_type push_result;

   sfwd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .out_space   (out_space),
      .push        (push),
      .push_result (push_result)
   );

   sfwd_out_fifo u_out (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .push_result     (push_result),
      .space           (out_space),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_word_value  (rsp_word_value),
      .rsp_word_index  (rsp_word_index),
      .rsp_word_count  (rsp_word_count)
   );

endmodule
`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 1ps
`default_nettype none

import sfwd_pkg::*;

// Parser position within a frame; codes 6 and 7 never occur from reset and
// fall back to sync hunt.
typedef enum logic [2:0] {
   HUNT_SYNC0 = 3'd0,
   HUNT_SYNC1 = 3'd1,
   TAKE_LEN   = 3'd2,
   TAKE_IDENT = 3'd3,
   TAKE_LOW   = 3'd4,
   TAKE_HIGH  = 3'd5
} parse_state_type;

class deframe_scoreboard;
   parse_state_type state;
   logic [7:0]     bytes_left;
   logic [7:0]     byte_sum;
   logic [7:0]     low_byte;
   logic [6:0]     word_cnt;
   result_type     expected_q[$];
   int             errors;
   int             words_seen;
   int             accepted_seen;
   int             rejected_seen;

   function new();
      state         = HUNT_SYNC0;
      bytes_left    = '0;
      byte_sum      = '0;
      low_byte      = '0;
      word_cnt      = '0;
      errors        = 0;
      words_seen    = 0;
      accepted_seen = 0;
      rejected_seen = 0;
   endfunction

   // advance the parser by one accepted byte, queue the word or frame status it yields
   function void note_byte(logic [7:0] b);
      result_type r;
      r = '0;
      case (state)
         HUNT_SYNC1: begin
            state = (b == SYNC_BYTE) ? TAKE_LEN : HUNT_SYNC0;
         end
         TAKE_LEN: begin
            if (b < LEN_OVERHEAD || b[0] == 1'b0) begin
               state = HUNT_SYNC0;
            end else begin
               bytes_left = b - LEN_OVERHEAD;
               byte_sum   = '0;
               word_cnt   = '0;
               state      = TAKE_IDENT;
            end
         end
         TAKE_IDENT: begin
            state = (b == IDENT_BYTE) ? TAKE_LOW : HUNT_SYNC0;
         end
         TAKE_LOW: begin
            byte_sum = byte_sum + b;
            if (bytes_left == 8'd0) begin
               // checksum byte closes the frame
               r.result_kind = (byte_sum == 8'd0) ? KIND_ACCEPTED : KIND_REJECTED;
               r.word_count  = word_cnt;
               expected_q.push_back(r);
               byte_sum = '0;
               word_cnt = '0;
               state    = HUNT_SYNC0;
            end else begin
               low_byte = b;
               state    = TAKE_HIGH;
            end
         end
         TAKE_HIGH: begin
            r.result_kind = KIND_WORD;
            r.word_value  = {b, low_byte};
            r.word_index  = word_cnt;
            expected_q.push_back(r);
            byte_sum   = byte_sum + b;
            bytes_left = (bytes_left >= WORD_BYTES) ? bytes_left - WORD_BYTES : 8'd0;
            word_cnt   = word_cnt + 7'd1;
            state      = TAKE_LOW;
         end
         default: begin
            state = (b == SYNC_BYTE) ? HUNT_SYNC1 : HUNT_SYNC0;
         end
      endcase
   endfunction

   function void check_result(logic [KIND_W-1:0] kind, logic [VALUE_W-1:0] value,
                              logic [INDEX_W-1:0] index, logic [COUNT_W-1:0] count);
      result_type exp;
      if (expected_q.size() == 0) begin
         $error("unexpected item: kind %0d value %h index %0d count %0d",
                kind, value, index, count);
         errors++;
         return;
      end
      exp = expected_q.pop_front();
      if (kind !== exp.result_kind) begin
         $error("result_kind: expected %0d, got %0d", exp.result_kind, kind);
         errors++;
      end
      if (value !== exp.word_value) begin
         $error("word_value: expected %h, got %h", exp.word_value, value);
         errors++;
      end
      if (index !== exp.word_index) begin
         $error("word_index: expected %0d, got %0d", exp.word_index, index);
         errors++;
      end
      if (count !== exp.word_count) begin
         $error("word_count: expected %0d, got %0d", exp.word_count, count);
         errors++;
      end
      case (exp.result_kind)
         KIND_WORD:     words_seen++;
         KIND_ACCEPTED: accepted_seen++;
         default:       rejected_seen++;
      endcase
   endfunction
endclass

module tb_top;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [7:0]          req_rx_byte = 8'd0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [KIND_W-1:0]   rsp_result_kind;
   logic [VALUE_W-1:0]  rsp_word_value;
   logic [INDEX_W-1:0]  rsp_word_index;
   logic [COUNT_W-1:0]  rsp_word_count;

   deframe_scoreboard   board;
   int                  send_idle_pct = 0;
   int                  stall_pct = 0;
   logic                hold_rsp = 1'b0;
   int                  bytes_sent = 0;
   logic [7:0]          tx_bytes[$];

   sync_frame_word_deframer u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_word_value  (rsp_word_value),
      .rsp_word_index  (rsp_word_index),
      .rsp_word_count  (rsp_word_count)
   );

   always #5 clock = ~clock;

   // result side: check what was taken at this edge, then pick next stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result(rsp_result_kind, rsp_word_value, rsp_word_index, rsp_word_count);
      if (hold_rsp)
         rsp_stall <= 1'b1;
      else
         rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_byte(b);
      bytes_sent++;
   endtask

   task automatic send_tx(input int count);
      for (int i = 0; i < count; i++)
         send_byte(tx_bytes[i]);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.expected_q.size() != 0) @(posedge clock);
   endtask

   // build a frame of n_words words; cut > 0 sends only its first cut bytes
   task automatic send_frame(input int n_words, input bit good_sum, input int cut);
      logic [7:0] sum;
      logic [7:0] b;
      sum = '0;
      tx_bytes = '{8'hFF, 8'hFF, 8'(2 * n_words + 3), 8'h00};
      for (int i = 0; i < 2 * n_words; i++) begin
         case ($urandom_range(9))
            0:       b = 8'h00;
            1:       b = 8'hFF;
            default: b = 8'($urandom_range(255));
         endcase
         tx_bytes.push_back(b);
         sum = sum + b;
      end
      b = 8'(0) - sum;
      if (!good_sum)
         b = b + 8'($urandom_range(255, 1));
      tx_bytes.push_back(b);
      send_tx((cut > 0 && cut < tx_bytes.size()) ? cut : tx_bytes.size());
   endtask

   task automatic random_traffic(input int n_bytes);
      int stop_at;
      int pick;
      stop_at = bytes_sent + n_bytes;
      while (bytes_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            send_frame($urandom_range(8), 1'b1, 0);
         end else if (pick < 70) begin
            send_frame($urandom_range(8), 1'b0, 0);
         end else if (pick < 77) begin
            // length below the overhead or even
            tx_bytes = '{8'hFF, 8'hFF,
                         $urandom_range(1) ? 8'($urandom_range(2))
                                           : 8'($urandom_range(254, 2)) & 8'hFE};
            send_tx(3);
         end else if (pick < 84) begin
            tx_bytes = '{8'hFF, 8'hFF, 8'(2 * $urandom_range(6) + 3),
                         8'($urandom_range(255, 1))};
            send_tx(4);
         end else if (pick < 92) begin
            repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)));
         end else begin
            send_frame($urandom_range(8, 1), 1'b1, $urandom_range(12, 3));
         end
         if ($urandom_range(99) < 5)
            drain_results();
      end
   endtask

   initial begin
      board = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: sync miss, short and even lengths, bad identifier,
      // empty frame rejected, two-word frame with extreme words accepted
      tx_bytes = '{8'hFF, 8'h12, 8'hFF, 8'hFF, 8'h02, 8'hFF, 8'hFF, 8'h04,
                   8'hFF, 8'hFF, 8'h03, 8'h07, 8'hFF, 8'hFF, 8'h03, 8'h00, 8'h05,
                   8'hFF, 8'hFF, 8'h07, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h02};
      send_tx(tx_bytes.size());
      drain_results();

      // no idling: longest frame (length byte 0xFF), then a long result hold-off
      send_frame(126, 1'b1, 0);
      drain_results();
      fork
         begin
            hold_rsp <= 1'b1;
            repeat (60) @(posedge clock);
            hold_rsp <= 1'b0;
         end
         send_frame(14, 1'b1, 0);
      join
      random_traffic(70);
      drain_results();

      send_idle_pct = 85;
      stall_pct     = 0;
      random_traffic(70);
      drain_results();

      send_idle_pct = 0;
      stall_pct     = 85;
      random_traffic(70);
      drain_results();

      send_idle_pct = 32;
      stall_pct     = 32;
      random_traffic(70);
      drain_results();

      stall_pct = 0;
      repeat (10) @(posedge clock);
      $display("Run covered %0d bytes: %0d words, %0d frames passed checksum, %0d failed.",
               bytes_sent, board.words_seen, board.accepted_seen, board.rejected_seen);
      if (board.errors == 0 && board.expected_q.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout with %0d results outstanding", board.expected_q.size());
      $display("DONE: errors detected");
      $finish;
   end

endmodule

`default_nettype wire
